// File: rtl/imu_caf_pkg.sv
// Shared types, constants and tables for the IMU complementary attitude filter.
package imu_caf_pkg;

  // CORDIC iteration count and arctangent table depth
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int STEP_W       = $clog2(TABLE_LEN);

  // bit-serial square root of a 32-bit radicand: one result bit per cycle
  localparam int          SQRT_ITERS = 16;
  localparam logic [31:0] SQRT_BIT0  = 32'h4000_0000;

  // angle widths: clamped Q16.16 degrees and CORDIC working width
  localparam int ANG_W = 25;
  localparam int CW    = 28;

  localparam logic signed [ANG_W-1:0] ANG_MAX     = 25'sd11796480;
  localparam logic signed [ANG_W-1:0] ANG_MIN     = -25'sd11796480;
  localparam logic signed [CW-1:0]    ANG_QUARTER = 28'sd5898240;

  // (180/pi) * 2^16 / (4096 * 10^6) * 2^32
  localparam logic signed [23:0] GYRO_K      = 24'sd3937336;
  localparam logic [15:0]        BLEND_RESET = 16'd64225;
  localparam logic signed [43:0] ROUND_HALF  = 44'sd32768;

  // datapath micro-operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_Y,
    OP_SQ_Z,
    OP_SQRT_STEP,
    OP_CORDIC_INIT,
    OP_CORDIC_STEP,
    OP_CORDIC_STORE,
    OP_RATE_DT,
    OP_GYRO_K,
    OP_SUM,
    OP_MUL_OLD,
    OP_MUL_ACC,
    OP_EST_STORE,
    OP_OUT_LOAD
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQRT,
    ST_C_INIT,
    ST_C_ITER,
    ST_C_STORE,
    ST_RATE_DT,
    ST_GYRO_K,
    ST_SUM,
    ST_MUL_OLD,
    ST_MUL_ACC,
    ST_EST,
    ST_OUT
  } ctrl_state_t;

  // command from controller to datapath
  typedef struct packed {
    dp_op_t            op;
    logic              pitch;  // 0: roll channel, 1: pitch channel
    logic [STEP_W-1:0] step;   // CORDIC iteration index
  } dp_cmd_t;

  // atan(2^-i) in Q16.16 degrees
  function automatic logic signed [CW-1:0] atan_deg(input logic [STEP_W-1:0] i);
    logic signed [CW-1:0] r;
    case (i)
      5'd0:    r = 28'sd2949120;
      5'd1:    r = 28'sd1740967;
      5'd2:    r = 28'sd919879;
      5'd3:    r = 28'sd466945;
      5'd4:    r = 28'sd234379;
      5'd5:    r = 28'sd117304;
      5'd6:    r = 28'sd58666;
      5'd7:    r = 28'sd29335;
      5'd8:    r = 28'sd14668;
      5'd9:    r = 28'sd7334;
      5'd10:   r = 28'sd3667;
      5'd11:   r = 28'sd1833;
      5'd12:   r = 28'sd917;
      5'd13:   r = 28'sd458;
      5'd14:   r = 28'sd229;
      5'd15:   r = 28'sd115;
      5'd16:   r = 28'sd57;
      5'd17:   r = 28'sd29;
      5'd18:   r = 28'sd14;
      5'd19:   r = 28'sd7;
      5'd20:   r = 28'sd4;
      5'd21:   r = 28'sd2;
      5'd22:   r = 28'sd1;
      default: r = 28'sd0;
    endcase
    return r;
  endfunction

  // saturate to +-180 degrees
  function automatic logic signed [ANG_W-1:0] clamp_ang(input logic signed [CW-1:0] v);
    logic signed [ANG_W-1:0] r;
    if (v > CW'(ANG_MAX)) begin
      r = ANG_MAX;
    end else if (v < CW'(ANG_MIN)) begin
      r = ANG_MIN;
    end else begin
      r = ANG_W'(v);
    end
    return r;
  endfunction

endpackage

// File: rtl/imu_caf_ctrl.sv
// Sequencer for the attitude filter: steps the datapath through one sample.
module imu_caf_ctrl
  import imu_caf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  ctrl_state_t       state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  logic              pitch, pitch_next;
  logic              out_valid_next;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      pitch     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      pitch     <= pitch_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    pitch_next     = pitch;
    out_valid_next = out_valid && out_stall;
    cmd.op         = OP_NONE;
    cmd.pitch      = pitch;
    cmd.step       = cnt;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_SQ_Y;
        end
      end
      ST_SQ_Y: begin
        cmd.op     = OP_SQ_Y;
        state_next = ST_SQ_Z;
      end
      ST_SQ_Z: begin
        cmd.op     = OP_SQ_Z;
        cnt_next   = '0;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (cnt == STEP_W'(SQRT_ITERS - 1)) begin
          cnt_next   = '0;
          pitch_next = 1'b0;
          state_next = ST_C_INIT;
        end else begin
          cnt_next = cnt + STEP_W'(1);
        end
      end
      ST_C_INIT: begin
        cmd.op     = OP_CORDIC_INIT;
        cnt_next   = '0;
        state_next = ST_C_ITER;
      end
      ST_C_ITER: begin
        cmd.op = OP_CORDIC_STEP;
        if (cnt == STEP_W'(CORDIC_ITERS - 1)) begin
          state_next = ST_C_STORE;
        end else begin
          cnt_next = cnt + STEP_W'(1);
        end
      end
      ST_C_STORE: begin
        cmd.op = OP_CORDIC_STORE;
        if (!pitch) begin
          pitch_next = 1'b1;
          state_next = ST_C_INIT;
        end else begin
          pitch_next = 1'b0;
          state_next = ST_RATE_DT;
        end
      end
      ST_RATE_DT: begin
        cmd.op     = OP_RATE_DT;
        state_next = ST_GYRO_K;
      end
      ST_GYRO_K: begin
        cmd.op     = OP_GYRO_K;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.op     = OP_SUM;
        state_next = ST_MUL_OLD;
      end
      ST_MUL_OLD: begin
        cmd.op     = OP_MUL_OLD;
        state_next = ST_MUL_ACC;
      end
      ST_MUL_ACC: begin
        cmd.op     = OP_MUL_ACC;
        state_next = ST_EST;
      end
      ST_EST: begin
        cmd.op = OP_EST_STORE;
        if (!pitch) begin
          pitch_next = 1'b1;
          state_next = ST_RATE_DT;
        end else begin
          pitch_next = 1'b0;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait until the output register is free or being emptied
        if (!out_valid || !out_stall) begin
          cmd.op         = OP_OUT_LOAD;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/imu_caf_dp.sv
// Datapath: sample registers, shared multiplier, square root, CORDIC and blend.
module imu_caf_dp
  import imu_caf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] rate_x,
  input  logic signed [15:0] rate_y,
  input  logic [15:0]        step_time,
  output logic signed [16:0] roll_angle,
  output logic signed [16:0] pitch_angle
);

  // sample registers
  logic signed [15:0] ax, ay, az, gx, gy;
  logic [15:0]        dt;

  // square root
  logic [31:0] sq_rem, sq_root, sq_bit;
  logic [32:0] sq_trial;
  logic        sq_ge;

  // CORDIC
  logic signed [CW-1:0] cx, cy, cz;
  logic                 c_zero;
  logic signed [CW-1:0] xs, ys, sx, sy;
  logic signed [16:0]   ix, iy;
  logic                 y_pos;

  // blend
  logic [15:0]             weight;
  logic signed [17:0]      w;
  logic signed [ANG_W-1:0] tilt_roll, tilt_pitch, est_roll, est_pitch;
  logic signed [ANG_W-1:0] acc_sel, est_sel;
  logic signed [31:0]      rate_dt;
  logic signed [22:0]      inc;
  logic signed [25:0]      sum;
  logic signed [43:0]      bacc;

  // shared multiplier
  logic signed [31:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [55:0] prod;

  assign w       = 18'sd65536 - $signed({2'b00, weight});
  assign acc_sel = cmd.pitch ? tilt_pitch : tilt_roll;
  assign est_sel = cmd.pitch ? est_pitch : est_roll;

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_SQ_Y: begin
        mul_a = 32'(ay);
        mul_b = 24'(ay);
      end
      OP_SQ_Z: begin
        mul_a = 32'(az);
        mul_b = 24'(az);
      end
      OP_RATE_DT: begin
        mul_a = cmd.pitch ? 32'(gy) : 32'(gx);
        mul_b = 24'($signed({1'b0, dt}));
      end
      OP_GYRO_K: begin
        mul_a = rate_dt;
        mul_b = GYRO_K;
      end
      OP_MUL_OLD: begin
        mul_a = 32'(sum);
        mul_b = 24'($signed({1'b0, weight}));
      end
      OP_MUL_ACC: begin
        mul_a = 32'(acc_sel);
        mul_b = 24'(w);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // square root trial subtraction
  assign sq_trial = {1'b0, sq_root} + {1'b0, sq_bit};
  assign sq_ge    = ({1'b0, sq_rem} >= sq_trial);

  // CORDIC start vector: roll uses (az, ay), pitch uses (root, -ax), both scaled by 256
  always_comb begin
    if (cmd.pitch) begin
      ix = $signed({1'b0, sq_root[15:0]});
      iy = -17'(ax);
    end else begin
      ix = 17'(az);
      iy = 17'(ay);
    end
    sx = CW'($signed({ix, 8'h00}));
    sy = CW'($signed({iy, 8'h00}));
  end

  assign xs    = cx >>> cmd.step;
  assign ys    = cy >>> cmd.step;
  assign y_pos = !cy[CW-1] && (cy != '0);

  // operation registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        ax <= accel_x;
        ay <= accel_y;
        az <= accel_z;
        gx <= rate_x;
        gy <= rate_y;
        dt <= step_time;
      end
      OP_SQ_Y: begin
        sq_rem <= prod[31:0];
      end
      OP_SQ_Z: begin
        sq_rem  <= sq_rem + prod[31:0];
        sq_root <= '0;
        sq_bit  <= SQRT_BIT0;
      end
      OP_SQRT_STEP: begin
        if (sq_ge) begin
          sq_rem  <= sq_rem - sq_trial[31:0];
          sq_root <= (sq_root >> 1) + sq_bit;
        end else begin
          sq_root <= sq_root >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      OP_CORDIC_INIT: begin
        c_zero <= (ix == '0) && (iy == '0);
        // left half-plane: turn by a quarter circle first
        if (sx[CW-1]) begin
          if (!sy[CW-1]) begin
            cx <= sy;
            cy <= -sx;
            cz <= ANG_QUARTER;
          end else begin
            cx <= -sy;
            cy <= sx;
            cz <= -ANG_QUARTER;
          end
        end else begin
          cx <= sx;
          cy <= sy;
          cz <= '0;
        end
      end
      OP_CORDIC_STEP: begin
        if (y_pos) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + atan_deg(cmd.step);
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - atan_deg(cmd.step);
        end
      end
      OP_CORDIC_STORE: begin
        if (cmd.pitch) begin
          tilt_pitch <= c_zero ? '0 : clamp_ang(cz);
        end else begin
          tilt_roll <= c_zero ? '0 : clamp_ang(cz);
        end
      end
      OP_RATE_DT: begin
        rate_dt <= 32'(prod);
      end
      OP_GYRO_K: begin
        inc <= prod[54:32];
      end
      OP_SUM: begin
        sum <= 26'(est_sel) + 26'(inc);
      end
      OP_MUL_OLD: begin
        bacc <= 44'(prod) + ROUND_HALF;
      end
      OP_MUL_ACC: begin
        bacc <= bacc + 44'(prod);
      end
      OP_OUT_LOAD: begin
        roll_angle  <= est_roll[ANG_W-1:8];
        pitch_angle <= est_pitch[ANG_W-1:8];
      end
      default: begin
      end
    endcase
  end

  // filter state and blend weight
  always_ff @(posedge clk) begin
    if (rst) begin
      est_roll  <= '0;
      est_pitch <= '0;
      weight    <= BLEND_RESET;
    end else begin
      if (cfg_we) begin
        weight <= cfg_data;
      end
      if (cmd.op == OP_EST_STORE) begin
        if (cmd.pitch) begin
          est_pitch <= clamp_ang(bacc[43:16]);
        end else begin
          est_roll <= clamp_ang(bacc[43:16]);
        end
      end
    end
  end

endmodule

// File: rtl/imu_complementary_attitude_filter_unit.sv
// A new sample is taken only after the previous result is loaded into the output register.
// The pace is set by the bit-serial square root, the one CORDIC unit run for roll then
// pitch, and the shared multiplier that does both blends in series. The result waits in
// an output register.
// Reset (rst, synchronous): estimates cleared, blend weight back to 64225, sequencer idle.
module imu_complementary_attitude_filter_unit
  import imu_caf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] rate_x,
  input  logic signed [15:0] rate_y,
  input  logic [15:0]        step_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] roll_angle,
  output logic signed [16:0] pitch_angle,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        blend_weight
);

  dp_cmd_t cmd;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  imu_caf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  imu_caf_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (blend_weight),
    .accel_x     (accel_x),
    .accel_y     (accel_y),
    .accel_z     (accel_z),
    .rate_x      (rate_x),
    .rate_y      (rate_y),
    .step_time   (step_time),
    .roll_angle  (roll_angle),
    .pitch_angle (pitch_angle)
  );

endmodule

// File: rtl/imu_caf_checker.sv
// Port-level checks for the attitude filter, bound to the top level.
module imu_caf_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [16:0] roll_angle,
  input logic signed [16:0] pitch_angle
);

  // a sample transfer makes the block busy
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after sample transfer");

  // an idle block with no pending result does not produce one next cycle
  a_no_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !in_stall |=> !out_valid)
    else $error("result appeared from an idle block");

  // a result only appears at the end of a busy period
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a sample in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(roll_angle) && $stable(pitch_angle))
    else $error("stalled result changed");

endmodule

bind imu_complementary_attitude_filter_unit imu_caf_checker u_imu_caf_checker (.*);

// File: sim/tb_imu_complementary_attitude_filter_unit.sv
// Self-checking testbench for the IMU complementary attitude filter: random samples, scoreboard.
module tb_imu_complementary_attitude_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import imu_caf_pkg::*;

  // predictor constants (Q16.16 degrees)
  localparam longint ANGLE_LIMIT  = 11796480;
  localparam longint QUARTER_TURN = 5898240;
  localparam longint RAD_TO_DEG_K = 3937336;
  localparam int     VECTOR_ITERS = CORDIC_ITERS;
  localparam int     QUIET_LIMIT  = 5000;
  localparam int     LONG_HOLD    = 700;

  localparam longint ATAN_STEP [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic [15:0]        step_time;
  } imu_sample_t;

  typedef struct {
    logic signed [16:0] roll;
    logic signed [16:0] pitch;
  } attitude_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] accel_x = '0;
  logic signed [15:0] accel_y = '0;
  logic signed [15:0] accel_z = '0;
  logic signed [15:0] rate_x = '0;
  logic signed [15:0] rate_y = '0;
  logic [15:0]        step_time = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [16:0] roll_angle;
  logic signed [16:0] pitch_angle;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_weight = '0;

  imu_sample_t sample_q[$];
  attitude_t   attitude_q[$];
  imu_sample_t cur_sample;
  attitude_t   want;

  // predictor state
  longint roll_est = 0;
  longint pitch_est = 0;
  longint gyro_weight = 64225;

  int queued_cnt = 0;
  int accepted_cnt = 0;
  int results_seen = 0;
  int fault_cnt = 0;
  int weight_writes = 0;
  int burst_left = 1;
  int gap_left = 0;
  int hold_left = 0;
  bit held_done = 1'b0;
  int pattern_cnt = 0;
  int stall_mode = 0;
  int quiet_cycles = 0;

  imu_complementary_attitude_filter_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .accel_x     (accel_x),
    .accel_y     (accel_y),
    .accel_z     (accel_z),
    .rate_x      (rate_x),
    .rate_y      (rate_y),
    .step_time   (step_time),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .roll_angle  (roll_angle),
    .pitch_angle (pitch_angle),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .blend_weight(cfg_weight)
  );

  always #5 clk = ~clk;

  // ---------------- predictor ----------------

  function automatic longint limit_angle(input longint v);
    if (v > ANGLE_LIMIT) return ANGLE_LIMIT;
    if (v < -ANGLE_LIMIT) return -ANGLE_LIMIT;
    return v;
  endfunction

  function automatic longint root_floor(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // vectoring CORDIC, angle of (x, y) in Q16.16 degrees
  function automatic longint tilt_angle(input longint y, input longint x);
    longint z;
    longint t;
    longint xs;
    longint ys;
    int     i;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 256;
    y = y * 256;
    // left half plane: rotate by a quarter turn first
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = QUARTER_TURN;
      end else begin
        x = -y;
        y = t;
        z = -QUARTER_TURN;
      end
    end
    for (i = 0; i < VECTOR_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_STEP[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_STEP[i];
      end
    end
    return limit_angle(z);
  endfunction

  function automatic longint fuse_angle(input longint old, input longint rate,
                                        input longint dt, input longint tilt);
    longint inc;
    longint acc;
    inc = (rate * dt * RAD_TO_DEG_K) >>> 32;
    acc = gyro_weight * (old + inc) + (65536 - gyro_weight) * tilt + 32768;
    return limit_angle(acc >>> 16);
  endfunction

  // advance the attitude estimate by one sample and return the reported angles
  function automatic attitude_t track_attitude(input imu_sample_t s);
    longint    ax;
    longint    ay;
    longint    az;
    longint    horiz;
    attitude_t a;
    ax = longint'(s.accel_x);
    ay = longint'(s.accel_y);
    az = longint'(s.accel_z);
    horiz = root_floor(longint'(ay * ay + az * az));
    roll_est = fuse_angle(roll_est, longint'(s.rate_x), longint'(s.step_time),
                          tilt_angle(ay, az));
    pitch_est = fuse_angle(pitch_est, longint'(s.rate_y), longint'(s.step_time),
                           tilt_angle(-ax, horiz));
    a.roll = 17'(roll_est >>> 8);
    a.pitch = 17'(pitch_est >>> 8);
    return a;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic imu_sample_t mk(input int ax, input int ay, input int az,
                                     input int gx, input int gy, input int dt);
    imu_sample_t s;
    s.accel_x = 16'(ax);
    s.accel_y = 16'(ay);
    s.accel_z = 16'(az);
    s.rate_x = 16'(gx);
    s.rate_y = 16'(gy);
    s.step_time = 16'(dt);
    return s;
  endfunction

  function automatic logic [15:0] corner_val();
    logic [15:0] v;
    case ($urandom_range(0, 4))
      0:       v = 16'h8000;
      1:       v = 16'hFFFF;
      2:       v = 16'h0000;
      3:       v = 16'h0001;
      default: v = 16'h7FFF;
    endcase
    return v;
  endfunction

  // mostly plausible motion, some full-range noise and corner values
  function automatic imu_sample_t random_sample();
    imu_sample_t s;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      s = mk(int'($urandom_range(0, 16000)) - 8000, int'($urandom_range(0, 16000)) - 8000,
             ($urandom_range(0, 1) ? 16384 : -16384) + int'($urandom_range(0, 4000)) - 2000,
             int'($urandom_range(0, 4000)) - 2000, int'($urandom_range(0, 4000)) - 2000,
             $urandom_range(500, 20000));
    end else if (pick < 9) begin
      s = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      s = mk(corner_val(), corner_val(), corner_val(), corner_val(), corner_val(),
             corner_val());
    end
    return s;
  endfunction

  task automatic post(input imu_sample_t s);
    sample_q.push_back(s);
    queued_cnt++;
  endtask

  task automatic post_random(input int n);
    repeat (n) post(random_sample());
  endtask

  // wait for all samples sent and all results back
  task automatic drain();
    while (accepted_cnt != queued_cnt || attitude_q.size() != 0) @(posedge clk);
  endtask

  // weight register write, only with the block idle
  task automatic set_blend(input logic [15:0] w);
    drain();
    cfg_valid <= 1'b1;
    cfg_weight <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    gyro_weight = longint'(w);
    weight_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic report_fault(input string what, input longint got, input longint exp_v);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, exp_v);
    fault_cnt++;
  endtask

  // ---------------- sender ----------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // input transfer: predict its result
      if (in_valid && !in_stall) begin
        attitude_q.push_back(track_attitude(cur_sample));
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          cur_sample = sample_q.pop_front();
          accel_x <= cur_sample.accel_x;
          accel_y <= cur_sample.accel_y;
          accel_z <= cur_sample.accel_z;
          rate_x <= cur_sample.rate_x;
          rate_y <= cur_sample.rate_y;
          step_time <= cur_sample.step_time;
          in_valid <= 1'b1;
          burst_left--;
          // end of burst: schedule a gap (sometimes none) after this transfer
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 160);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver and checker ----------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (attitude_q.size() == 0) begin
          report_fault("unexpected result, roll", roll_angle, 0);
        end else begin
          want = attitude_q.pop_front();
          if (roll_angle !== want.roll) report_fault("roll_angle", roll_angle, want.roll);
          if (pitch_angle !== want.pitch) report_fault("pitch_angle", pitch_angle, want.pitch);
        end
      end
      // stall pattern: one long hold-off, otherwise a randomly picked stall mode
      pattern_cnt++;
      if (pattern_cnt % 128 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held_done && results_seen >= 60) begin
        held_done = 1'b1;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(0, 1));
          2:       out_stall <= (pattern_cnt % 8) < 5;
          default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------- test sequence ----------------
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: reset weight
    post(mk(0, 0, 0, 0, 0, 0));                    // zero vectors, zero step
    post(mk(0, 0, 16384, 0, 0, 1000));             // level
    post(mk(0, 0, -16384, 0, 0, 1000));            // upside down, y zero
    post(mk(0, -1, -16384, 0, 0, 1000));           // negative base, y below zero
    post(mk(0, 1, -32768, 0, 0, 1000));            // negative base, y above zero
    post(mk(-32768, 32767, 32767, 32767, 32767, 65535));
    post(mk(32767, -32768, -32768, -32768, -32768, 65535));
    post(mk(32767, 0, 0, 0, 0, 1));
    post(mk(-32768, 0, 0, 0, 0, 1));
    post(mk(0, 32767, 0, 100, -100, 2000));
    post(mk(0, -32768, 0, -100, 100, 2000));
    post(mk(0, 0, 0, 32767, -32768, 65535));       // zero vector with gyro motion
    post(mk(0, 0, 0, -32768, 32767, 0));           // large rate, zero step
    post(mk(1, -1, 1, -1, 1, 1));

    // accelerometer only
    set_blend(16'd0);
    post(mk(16384, -9000, 12000, 32767, -32768, 65535));
    post(mk(-500, 20000, -3000, 0, 0, 1000));
    post(mk(0, 0, 0, 1000, 1000, 1000));

    // nearly gyro only, driven into saturation
    set_blend(16'hFFFF);
    repeat (8) post(mk(0, 0, 16384, 32767, 32767, 65535));

    // random phases over several weights
    set_blend(16'($urandom_range(1, 65534)));
    post_random(220);
    set_blend(BLEND_RESET);
    post_random(180);
    set_blend(16'd0);
    post_random(60);
    set_blend(16'hFFFF);
    post_random(140);

    drain();
    repeat (100) @(posedge clk);
    $display("Checked %0d samples (%0d results) over %0d weight writes,", accepted_cnt,
             results_seen, weight_writes);
    $display("including weights 0 and 65535, a long output hold-off and idle drains.");
    if (fault_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
